// ----- sv/plab_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the power-law adaptation bank.
// No dependencies; every other file of the block refers to this package.
package plab_pkg;

    localparam int PROCESSES_DEF = 4;
    localparam int COEF_BITS_DEF = 16;

    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = 31;
    localparam int GAIN_W   = 32;
    localparam int DECAYS_W = 64;
    localparam int INTEG_W  = 34;
    localparam int FB_HI_W  = GAIN_W + INTEG_W - 16;

    // shared multiplier operands: 33-bit signed by 25-bit signed
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DECAYS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DECAYS = 2'd3;

    // what a product in flight is for
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_FB_S_HI = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FB_S_LO = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FB_F_HI = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FB_F_LO = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SM_S    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SM_F    = 3'd5;

    typedef struct packed {
        logic [GAIN_W-1:0]   slow_gain;
        logic [GAIN_W-1:0]   fast_gain;
        logic [DECAYS_W-1:0] slow_decays;
        logic [DECAYS_W-1:0] fast_decays;
    } cfg_t;

    typedef struct packed {
        logic                      valid;
        logic [KIND_W-1:0]         kind;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_op_t;

    typedef struct packed {
        logic                      valid;
        logic [KIND_W-1:0]         kind;
        logic signed [MUL_P_W-1:0] prod;
    } mul_res_t;

endpackage

// ----- sv/plab_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the power-law adaptation bank: items, results, config.
// Widths come from plab_pkg.
interface plab_item_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [plab_pkg::SAMPLE_W-1:0]  sample;
    logic signed [plab_pkg::SAMPLE_W-1:0]  noise;
    logic                                  first_sample;

    modport source (output valid, sample, noise, first_sample, input ready);
    modport sink   (input valid, sample, noise, first_sample, output ready);
endinterface

interface plab_result_if;
    logic                           valid;
    logic                           ready;
    logic [plab_pkg::OUT_W-1:0]     slow_out;
    logic [plab_pkg::OUT_W-1:0]     fast_out;

    modport source (output valid, slow_out, fast_out, input ready);
    modport sink   (input valid, slow_out, fast_out, output ready);
endinterface

interface plab_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [plab_pkg::CFG_IDX_W-1:0]      index;
    logic [plab_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/plab_cfg.sv -----
`timescale 1ns / 1ps
// Configuration register file: gains and packed decay coefficients.
// Depends on plab_pkg and plab_if.
module plab_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    plab_cfg_if.sink          cfg,
    output plab_pkg::cfg_t    regs
);

    plab_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                plab_pkg::CFG_SLOW_GAIN:
                    regs_reg.slow_gain <= cfg.data[plab_pkg::GAIN_W-1:0];
                plab_pkg::CFG_FAST_GAIN:
                    regs_reg.fast_gain <= cfg.data[plab_pkg::GAIN_W-1:0];
                plab_pkg::CFG_SLOW_DECAYS:
                    regs_reg.slow_decays <= cfg.data;
                plab_pkg::CFG_FAST_DECAYS:
                    regs_reg.fast_decays <= cfg.data;
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ----- sv/plab_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product and a kind tag.
// Depends on plab_pkg.
module plab_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  plab_pkg::mul_op_t    op,
    output plab_pkg::mul_res_t   res
);

    logic                                 valid_reg;
    logic [plab_pkg::KIND_W-1:0]          kind_reg;
    logic signed [plab_pkg::MUL_P_W-1:0]  prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= op.kind;
        prod_reg <= op.a * op.b;
    end

    assign res.valid = valid_reg;
    assign res.kind  = kind_reg;
    assign res.prod  = prod_reg;

endmodule

// ----- sv/plab_core.sv -----
`timescale 1ns / 1ps
// Sequencer and datapath: feeds the shared multiplier, rectifies the outputs,
// updates the smoother banks and integrals. Depends on plab_pkg and plab_if.
module plab_core
#(
    parameter int PROCESSES = plab_pkg::PROCESSES_DEF,
    parameter int COEF_BITS = plab_pkg::COEF_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  plab_pkg::cfg_t       regs,
    plab_item_if.sink            items,
    plab_result_if.source        results,
    output plab_pkg::mul_op_t    op,
    input  plab_pkg::mul_res_t   res
);

    localparam int NSTEP  = 4 + 2 * PROCESSES;
    localparam int STEP_W = $clog2(NSTEP);
    localparam int IDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PAD_W  = plab_pkg::DECAYS_W + PROCESSES * COEF_BITS;
    localparam int ACC_W  = plab_pkg::MUL_P_W + 1;
    localparam int FB_W   = plab_pkg::FB_HI_W + 1;
    localparam int DIFF_W = FB_W + 2;
    localparam int OUT_W  = plab_pkg::OUT_W;
    localparam int INTEG_W = plab_pkg::INTEG_W;

    localparam logic [STEP_W-1:0] STEP_SM_S = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_SM_F = STEP_W'(4 + PROCESSES);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEP - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [IDX_W-1:0]           wr_idx_reg;
    logic [IDX_W-1:0]           iss_idx;

    logic signed [plab_pkg::SAMPLE_W-1:0] x_reg, nz_reg;
    logic                       clr_reg;

    logic [plab_pkg::FB_HI_W-1:0] fb_hi_reg;
    logic [OUT_W-1:0]           s1_reg, s2_reg;
    logic [INTEG_W-1:0]         integ_s_reg, integ_f_reg;
    logic [OUT_W-1:0]           sm_s_reg [PROCESSES];
    logic [OUT_W-1:0]           sm_f_reg [PROCESSES];

    logic                       out_valid_reg;
    logic [OUT_W-1:0]           slow_out_reg, fast_out_reg;

    logic [PAD_W-1:0]           dec_s_pad, dec_f_pad;
    logic [COEF_BITS-1:0]       coef_s [PROCESSES];
    logic [COEF_BITS-1:0]       coef_f [PROCESSES];

    logic [FB_W-1:0]            fb_full;
    logic signed [DIFF_W-1:0]   slow_diff, fast_diff;
    logic [OUT_W-1:0]           s_sel;
    logic signed [ACC_W-1:0]    sm_acc;
    logic [OUT_W-1:0]           new_e;
    logic [OUT_W-1:0]           e_prev;

    function automatic logic [OUT_W-1:0] rectify(input logic signed [DIFF_W-1:0] v);
        logic [OUT_W-1:0] r;
        begin
            if (v < 0)
            begin
                r = '0;
            end
            else if (v > $signed(DIFF_W'({OUT_W{1'b1}})))
            begin
                r = {OUT_W{1'b1}};
            end
            else
            begin
                r = v[OUT_W-1:0];
            end
            return r;
        end
    endfunction

    // coefficient bits past the 64-bit register read as zero
    assign dec_s_pad = {{(PROCESSES * COEF_BITS){1'b0}}, regs.slow_decays};
    assign dec_f_pad = {{(PROCESSES * COEF_BITS){1'b0}}, regs.fast_decays};

    for (genvar g = 0; g < PROCESSES; g++)
    begin : g_coef
        assign coef_s[g] = dec_s_pad[g * COEF_BITS +: COEF_BITS];
        assign coef_f[g] = dec_f_pad[g * COEF_BITS +: COEF_BITS];
    end

    // issue side
    always_comb
    begin
        if (step_reg < STEP_SM_F)
        begin
            iss_idx = IDX_W'(step_reg - STEP_SM_S);
        end
        else
        begin
            iss_idx = IDX_W'(step_reg - STEP_SM_F);
        end
    end

    always_comb
    begin
        op       = '0;
        op.valid = (state_reg == ST_RUN);
        e_prev   = '0;
        if (step_reg < STEP_SM_S)
        begin
            case (step_reg[1:0])
                2'd0:
                begin
                    op.kind = plab_pkg::KIND_FB_S_HI;
                    op.a    = plab_pkg::MUL_A_W'(regs.slow_gain);
                    op.b    = plab_pkg::MUL_B_W'(integ_s_reg[INTEG_W-1:16]);
                end
                2'd1:
                begin
                    op.kind = plab_pkg::KIND_FB_S_LO;
                    op.a    = plab_pkg::MUL_A_W'(regs.slow_gain);
                    op.b    = plab_pkg::MUL_B_W'(integ_s_reg[15:0]);
                end
                2'd2:
                begin
                    op.kind = plab_pkg::KIND_FB_F_HI;
                    op.a    = plab_pkg::MUL_A_W'(regs.fast_gain);
                    op.b    = plab_pkg::MUL_B_W'(integ_f_reg[INTEG_W-1:16]);
                end
                default:
                begin
                    op.kind = plab_pkg::KIND_FB_F_LO;
                    op.a    = plab_pkg::MUL_A_W'(regs.fast_gain);
                    op.b    = plab_pkg::MUL_B_W'(integ_f_reg[15:0]);
                end
            endcase
        end
        else if (step_reg < STEP_SM_F)
        begin
            e_prev  = clr_reg ? '0 : sm_s_reg[iss_idx];
            op.kind = plab_pkg::KIND_SM_S;
            op.a    = $signed({2'b00, e_prev}) - $signed({2'b00, s1_reg});
            op.b    = plab_pkg::MUL_B_W'(coef_s[iss_idx]);
        end
        else
        begin
            e_prev  = clr_reg ? '0 : sm_f_reg[iss_idx];
            op.kind = plab_pkg::KIND_SM_F;
            op.a    = $signed({2'b00, e_prev}) - $signed({2'b00, s2_reg});
            op.b    = plab_pkg::MUL_B_W'(coef_f[iss_idx]);
        end
    end

    // consume side
    assign fb_full   = FB_W'(fb_hi_reg) + FB_W'(res.prod[47:16]);
    assign slow_diff = DIFF_W'(x_reg) + DIFF_W'(nz_reg) - $signed({1'b0, fb_full});
    assign fast_diff = DIFF_W'(x_reg) - $signed({1'b0, fb_full});

    // E' = out + D*(E - out)/2^C, rounded half up
    assign s_sel  = (res.kind == plab_pkg::KIND_SM_S) ? s1_reg : s2_reg;
    assign sm_acc = $signed(ACC_W'(s_sel) << COEF_BITS) + ACC_W'(res.prod)
                    + $signed(ACC_W'(1) << (COEF_BITS - 1));
    assign new_e  = sm_acc[COEF_BITS +: OUT_W];

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            case (res.kind)
                plab_pkg::KIND_FB_S_HI,
                plab_pkg::KIND_FB_F_HI:
                    fb_hi_reg <= res.prod[plab_pkg::FB_HI_W-1:0];
                plab_pkg::KIND_FB_S_LO:
                    s1_reg <= rectify(slow_diff);
                plab_pkg::KIND_FB_F_LO:
                    s2_reg <= rectify(fast_diff);
                default:
                    fb_hi_reg <= fb_hi_reg;
            endcase
        end
        if ((state_reg == ST_IDLE) && items.valid)
        begin
            x_reg   <= items.sample;
            nz_reg  <= items.noise;
            clr_reg <= items.first_sample;
        end
        wr_idx_reg <= iss_idx;
    end

    // smoother banks and integrals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_s_reg <= '0;
            integ_f_reg <= '0;
            for (int i = 0; i < PROCESSES; i++)
            begin
                sm_s_reg[i] <= '0;
                sm_f_reg[i] <= '0;
            end
        end
        else if (res.valid && (res.kind == plab_pkg::KIND_SM_S))
        begin
            sm_s_reg[wr_idx_reg] <= new_e;
            integ_s_reg <= (wr_idx_reg == '0) ? INTEG_W'(new_e)
                                              : integ_s_reg + INTEG_W'(new_e);
        end
        else if (res.valid && (res.kind == plab_pkg::KIND_SM_F))
        begin
            sm_f_reg[wr_idx_reg] <= new_e;
            integ_f_reg <= (wr_idx_reg == '0) ? INTEG_W'(new_e)
                                              : integ_f_reg + INTEG_W'(new_e);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (items.valid)
                begin
                    state_next = ST_RUN;
                end
            ST_RUN:
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            ST_FINISH:
                state_next = ST_PUSH;
            ST_PUSH:
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else
            begin
                step_reg <= '0;
            end
            if ((state_reg == ST_PUSH) && (!out_valid_reg || results.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PUSH) && (!out_valid_reg || results.ready))
        begin
            slow_out_reg <= s1_reg;
            fast_out_reg <= s2_reg;
        end
    end

    assign items.ready      = (state_reg == ST_IDLE);
    assign results.valid    = out_valid_reg;
    assign results.slow_out = slow_out_reg;
    assign results.fast_out = fast_out_reg;

endmodule

// ----- sv/power_law_adaptation_exp_bank.sv -----
`timescale 1ns / 1ps
// Power-law adaptation by two banks of exponential smoothers (slow and fast path).
// Items are taken one at a time: a new item is accepted only once the result of the last
// one has gone to the output register, as the core has a single shared multiplier,
// which serves four feedback products and 2*PROCESSES smoother products for each item.
// Reset (rst_n, asynchronous, active low) clears control state, config registers, smoothers and integrals at once.
// Depends on plab_pkg, plab_if, plab_cfg, plab_mul and plab_core.
module power_law_adaptation_exp_bank
#(
    parameter int PROCESSES = plab_pkg::PROCESSES_DEF,
    parameter int COEF_BITS = plab_pkg::COEF_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    plab_item_if.sink      items,
    plab_result_if.source  results,
    plab_cfg_if.sink       cfg
);

    // Configuration registers; every write is taken, and each of the four
    // possible indices names one register.
    plab_pkg::cfg_t     cfg_regs;

    // One multiplier shared by every product: operands go in with a tag
    // that tells the core where the registered product belongs.
    plab_pkg::mul_op_t  mul_op;
    plab_pkg::mul_res_t mul_res;

    plab_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    plab_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mul_op),
        .res   (mul_res)
    );

    // The core steps through the feedback products first (slow high and low
    // halves, then fast), rectifies each output once its feedback is complete,
    // then runs the slow and fast smoother updates one per cycle. The finished
    // transaction is parked in an output register so the core can free up.
    plab_core
    #(
        .PROCESSES (PROCESSES),
        .COEF_BITS (COEF_BITS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (cfg_regs),
        .items   (items),
        .results (results),
        .op      (mul_op),
        .res     (mul_res)
    );

    // The core must drop ready straight after taking a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("ready held high after an accepted transaction");

    // Work on an accepted item starts with a multiply in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> mul_op.valid)
        else $error("no multiply issued after an accepted transaction");

    // No product may land while the core is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_res.valid |-> !items.ready)
        else $error("product arrived while the core was idle");

endmodule
